### design/ncew_pkg.sv
// Package for the neighbor color edge weight block: types, constants and exp tables.
`default_nettype none
package ncew_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int CMP_W     = 14;
   localparam int PIX_W     = 24;
   localparam int ADDR_W    = 4;

   localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
   localparam logic [1:0] REG_MAX_WEIGHT = 2'd1;
   localparam logic [1:0] REG_INV_SIGMA  = 2'd2;

   typedef struct packed {
      logic [7:0] lum;
      logic [7:0] chroma_a;
      logic [7:0] chroma_b;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [15:0] left_weight;
      logic        left_valid;
      logic [15:0] up_weight;
      logic        up_valid;
   } rsp_type;

   function automatic logic [16:0] e_int(input logic [3:0] i);
      logic [16:0] r;
      unique case (i)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd24109;
         4'd2:    r = 17'd8869;
         4'd3:    r = 17'd3263;
         4'd4:    r = 17'd1200;
         4'd5:    r = 17'd442;
         4'd6:    r = 17'd162;
         4'd7:    r = 17'd60;
         4'd8:    r = 17'd22;
         4'd9:    r = 17'd8;
         4'd10:   r = 17'd3;
         4'd11:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] e_hi(input logic [3:0] h);
      logic [16:0] r;
      unique case (h)
         4'd0:  r = 17'd65536;
         4'd1:  r = 17'd61565;
         4'd2:  r = 17'd57835;
         4'd3:  r = 17'd54331;
         4'd4:  r = 17'd51039;
         4'd5:  r = 17'd47947;
         4'd6:  r = 17'd45042;
         4'd7:  r = 17'd42313;
         4'd8:  r = 17'd39750;
         4'd9:  r = 17'd37341;
         4'd10: r = 17'd35079;
         4'd11: r = 17'd32954;
         4'd12: r = 17'd30957;
         4'd13: r = 17'd29081;
         4'd14: r = 17'd27319;
         4'd15: r = 17'd25664;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] e_lo(input logic [3:0] l);
      logic [16:0] r;
      unique case (l)
         4'd0:  r = 17'd65536;
         4'd1:  r = 17'd65280;
         4'd2:  r = 17'd65026;
         4'd3:  r = 17'd64772;
         4'd4:  r = 17'd64520;
         4'd5:  r = 17'd64268;
         4'd6:  r = 17'd64018;
         4'd7:  r = 17'd63768;
         4'd8:  r = 17'd63520;
         4'd9:  r = 17'd63272;
         4'd10: r = 17'd63025;
         4'd11: r = 17'd62780;
         4'd12: r = 17'd62535;
         4'd13: r = 17'd62291;
         4'd14: r = 17'd62048;
         4'd15: r = 17'd61806;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

### design/ncew_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module ncew_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### design/neighbor_color_edge_weights.sv
// Top level of the neighbor color edge weight block: position tracking, line store and weights.
// A new input item is taken only in the idle state, once the previous result has been loaded
// into the output register. The two weights share one sequential datapath whose 13-step
// square root dominates.
// Reset is synchronous and active high; it restores the registers to their defaults and
// clears position, previous pixel and handshake state. The line store is not cleared.
`default_nettype none
module neighbor_color_edge_weights (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire ncew_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output ncew_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [ncew_pkg::ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic      [31:0]                   csr_prdata,
   output logic                               csr_pready
);

   localparam int CW = ncew_pkg::COL_W;
   localparam int KW = ncew_pkg::CMP_W;

   // Configuration registers, written through the APB-style port.
   logic [11:0] line_width_ff;
   logic [15:0] max_weight_ff;
   logic [15:0] inv_sigma_ff;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= 12'd640;
         max_weight_ff <= 16'd256;
         inv_sigma_ff  <= 16'd26;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            ncew_pkg::REG_LINE_WIDTH: line_width_ff <= csr_pwdata[11:0];
            ncew_pkg::REG_MAX_WEIGHT: max_weight_ff <= csr_pwdata[15:0];
            ncew_pkg::REG_INV_SIGMA:  inv_sigma_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         ncew_pkg::REG_LINE_WIDTH: csr_prdata = {20'd0, line_width_ff};
         ncew_pkg::REG_MAX_WEIGHT: csr_prdata = {16'd0, max_weight_ff};
         ncew_pkg::REG_INV_SIGMA:  csr_prdata = {16'd0, inv_sigma_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // The effective row width is the register clamped to one through the store depth.
   logic [KW-1:0] eff_width;
   always_comb begin
      if (line_width_ff == 12'd0) begin
         eff_width = KW'(1);
      end else if (KW'(line_width_ff) > KW'(ncew_pkg::MAX_WIDTH)) begin
         eff_width = KW'(ncew_pkg::MAX_WIDTH);
      end else begin
         eff_width = KW'(line_width_ff);
      end
   end

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_SQ, S_ROOT, S_MX, S_E1, S_E2, S_W, S_DONE
   } state_type;

   state_type   state_ff;
   logic [CW-1:0] col_ff;       // column of the next item
   logic          past_row_ff;  // set once the first row of the frame has ended
   logic [23:0]   prev_ff;      // previous pixel, the left neighbor of the next item
   logic [23:0]   cur_ff;
   logic [23:0]   left_px_ff;
   logic [23:0]   up_px_ff;
   logic [CW-1:0] item_col_ff;
   logic          left_ok_ff;
   logic          up_ok_ff;
   logic          edge_ff;      // low while the left weight is worked, high for the upper one
   logic [25:0]   rad_ff;       // square root remainder
   logic [25:0]   root_ff;
   logic [3:0]    step_ff;
   logic          big_ff;       // exponent at or beyond 16, weight is zero
   logic [11:0]   x_ff;
   logic [16:0]   e_ff;
   logic [15:0]   left_w_ff;
   logic [15:0]   up_w_ff;
   logic          rsp_valid_ff;
   ncew_pkg::rsp_type rsp_data_ff;

   logic        req_accept;
   logic [23:0] req_px;
   logic [23:0] ram_rdata;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign req_px     = {req_data.chroma_b, req_data.chroma_a, req_data.lum};
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Position of the accepted item: a frame start clears it, and a column at or
   // beyond the width (after the width was lowered) wraps into the next row first.
   logic [CW-1:0] pre_col;
   logic          pre_row;
   logic [CW-1:0] acc_col;
   logic          acc_row;
   logic [KW-1:0] next_col;
   always_comb begin
      pre_col = req_data.frame_start ? '0 : col_ff;
      pre_row = req_data.frame_start ? 1'b0 : past_row_ff;
      if (KW'(pre_col) >= eff_width) begin
         acc_col = '0;
         acc_row = 1'b1;
      end else begin
         acc_col = pre_col;
         acc_row = pre_row;
      end
      next_col = KW'(acc_col) + KW'(1);
   end

   ncew_ram #(
      .WIDTH(ncew_pkg::PIX_W),
      .DEPTH(ncew_pkg::MAX_WIDTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (state_ff == S_RD),
      .wr_addr(item_col_ff),
      .wr_data(cur_ff),
      .rd_en  (req_accept),
      .rd_addr(acc_col),
      .rd_data(ram_rdata)
   );

   // Sum of squared channel differences of the pixel pair in work.
   logic [23:0] nb_px;
   logic [7:0]  dl, da, db;
   logic [17:0] sum_sq;
   always_comb begin
      nb_px  = edge_ff ? up_px_ff : left_px_ff;
      dl     = (cur_ff[7:0]   >= nb_px[7:0])   ? cur_ff[7:0]   - nb_px[7:0]
                                               : nb_px[7:0]   - cur_ff[7:0];
      da     = (cur_ff[15:8]  >= nb_px[15:8])  ? cur_ff[15:8]  - nb_px[15:8]
                                               : nb_px[15:8]  - cur_ff[15:8];
      db     = (cur_ff[23:16] >= nb_px[23:16]) ? cur_ff[23:16] - nb_px[23:16]
                                               : nb_px[23:16] - cur_ff[23:16];
      sum_sq = 18'(dl * dl) + 18'(da * da) + 18'(db * db);
   end

   // One step of the bit-pair square root; the trial bit walks down from 2^24.
   logic [25:0] trial_bit;
   logic [25:0] trial;
   assign trial_bit = 26'(1) << (5'd24 - {step_ff, 1'b0});
   assign trial     = root_ff + trial_bit;

   logic [28:0] x_prod;
   logic [33:0] e1_prod;
   logic [33:0] e2_prod;
   logic [17:0] e2_round;
   logic [32:0] w_prod;
   logic [16:0] w_round;
   logic [15:0] w_sat;
   always_comb begin
      x_prod   = 29'(root_ff[12:0]) * 29'(inv_sigma_ff);
      e1_prod  = 34'(ncew_pkg::e_int(x_ff[11:8])) * 34'(ncew_pkg::e_hi(x_ff[7:4]))
                 + 34'd32768;
      e2_prod  = 34'(e_ff) * 34'(ncew_pkg::e_lo(x_ff[3:0])) + 34'd32768;
      e2_round = e2_prod[33:16];
      w_prod   = 33'(max_weight_ff) * 33'(e_ff[15:0]) + 33'd32768;
      w_round  = w_prod[32:16];
      w_sat    = w_round[16] ? 16'hFFFF : w_round[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         past_row_ff  <= 1'b0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A finished item loads the output register when it is free or drained.
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  cur_ff      <= req_px;
                  left_px_ff  <= prev_ff;
                  prev_ff     <= req_px;
                  item_col_ff <= acc_col;
                  left_ok_ff  <= (acc_col != '0);
                  up_ok_ff    <= acc_row;
                  if (next_col >= eff_width) begin
                     col_ff      <= '0;
                     past_row_ff <= 1'b1;
                  end else begin
                     col_ff      <= next_col[CW-1:0];
                     past_row_ff <= acc_row;
                  end
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               up_px_ff <= ram_rdata;
               edge_ff  <= 1'b0;
               state_ff <= S_SQ;
            end
            S_SQ: begin
               rad_ff   <= {sum_sq, 8'd0};
               root_ff  <= '0;
               step_ff  <= '0;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               if (rad_ff >= trial) begin
                  rad_ff  <= rad_ff - trial;
                  root_ff <= (root_ff >> 1) + trial_bit;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               step_ff <= step_ff + 4'd1;
               if (step_ff == 4'd12) begin
                  state_ff <= S_MX;
               end
            end
            S_MX: begin
               big_ff   <= (x_prod[28:16] != '0);
               x_ff     <= x_prod[15:4];
               state_ff <= S_E1;
            end
            S_E1: begin
               e_ff     <= e1_prod[32:16];
               state_ff <= S_E2;
            end
            S_E2: begin
               if (big_ff) begin
                  e_ff <= '0;
               end else if (e2_round > 18'd65535) begin
                  e_ff <= 17'd65535;
               end else begin
                  e_ff <= e2_round[16:0];
               end
               state_ff <= S_W;
            end
            S_W: begin
               if (edge_ff) begin
                  up_w_ff  <= w_sat;
                  state_ff <= S_DONE;
               end else begin
                  left_w_ff <= w_sat;
                  edge_ff   <= 1'b1;
                  state_ff  <= S_SQ;
               end
            end
            S_DONE: begin
               // The result waits here only while the previous one is still held.
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff.left_weight  <= left_ok_ff ? left_w_ff : 16'd0;
                  rsp_data_ff.left_valid   <= left_ok_ff;
                  rsp_data_ff.up_weight    <= up_ok_ff ? up_w_ff : 16'd0;
                  rsp_data_ff.up_valid     <= up_ok_ff;
                  state_ff                 <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // An accepted item always starts with the line store read.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_RD)
      else $error("accepted item did not start the line store read");

   // A masked weight is delivered as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.left_valid |-> rsp_data.left_weight == 16'd0)
      else $error("left weight not zero in column zero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.up_valid |-> rsp_data.up_weight == 16'd0)
      else $error("up weight not zero in first row");

   // A new result is loaded only when the output register is free or drained.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("held result item was overwritten");

endmodule
`default_nettype wire
